// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

    localparam int COORD_BITS = 16;

    typedef logic [COORD_BITS-1:0] coord_t;

    localparam coord_t COORD_ONE = coord_t'(1);
    localparam coord_t COORD_MAX = '1;

    localparam logic [4:0] KIND_NUM    = 5'd0;
    localparam logic [4:0] KIND_ID     = 5'd1;
    localparam logic [4:0] KIND_IF     = 5'd2;
    localparam logic [4:0] KIND_ELSE   = 5'd3;
    localparam logic [4:0] KIND_PLUS   = 5'd4;
    localparam logic [4:0] KIND_MINUS  = 5'd5;
    localparam logic [4:0] KIND_STAR   = 5'd6;
    localparam logic [4:0] KIND_SLASH  = 5'd7;
    localparam logic [4:0] KIND_EQ     = 5'd8;
    localparam logic [4:0] KIND_LPAREN = 5'd9;
    localparam logic [4:0] KIND_RPAREN = 5'd10;
    localparam logic [4:0] KIND_SEMI   = 5'd11;
    localparam logic [4:0] KIND_GT     = 5'd12;
    localparam logic [4:0] KIND_LT     = 5'd13;
    localparam logic [4:0] KIND_LBRACE = 5'd14;
    localparam logic [4:0] KIND_RBRACE = 5'd15;
    localparam logic [4:0] KIND_EOF    = 5'd16;
    localparam logic [4:0] KIND_ERR    = 5'd17;

    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_UNDER   = 8'h5F;
    localparam logic [31:0] KW_IF      = 32'h0000_6966;
    localparam logic [31:0] KW_ELSE    = 32'h656C_7365;

    localparam logic [1:0] QUEUE_DEPTH = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_ID,
        MODE_HALT
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic [15:0] length;
        logic [7:0]  bad_char;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    typedef struct packed {
        logic       room;
        logic [1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } op_match_t;

    function automatic coord_t sat_inc(coord_t v);
        return (v == COORD_MAX) ? v : v + COORD_ONE;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic op_match_t op_lookup(logic [7:0] c);
        op_match_t m;
        m.hit  = 1'b1;
        m.kind = KIND_ERR;
        unique case (c)
            8'h2B:   m.kind = KIND_PLUS;
            8'h2D:   m.kind = KIND_MINUS;
            8'h2A:   m.kind = KIND_STAR;
            8'h2F:   m.kind = KIND_SLASH;
            8'h3D:   m.kind = KIND_EQ;
            8'h28:   m.kind = KIND_LPAREN;
            8'h29:   m.kind = KIND_RPAREN;
            8'h3B:   m.kind = KIND_SEMI;
            8'h3E:   m.kind = KIND_GT;
            8'h3C:   m.kind = KIND_LT;
            8'h7B:   m.kind = KIND_LBRACE;
            8'h7D:   m.kind = KIND_RBRACE;
            default: m.hit  = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/cst_in_if.sv =====
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, ch, is_end, input ready);
    modport sink (input valid, ch, is_end, output ready);
endinterface

// ===== rtl/core/cst_out_if.sv =====
interface cst_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [15:0] length;
    logic [7:0]  bad_char;
    logic        last;

    modport source (output valid, kind, start_line, start_col, length, bad_char, last,
                    input ready);
    modport sink (input valid, kind, start_line, start_col, length, bad_char, last,
                  output ready);
endinterface

// ===== rtl/core/cst_lexer.sv =====
module cst_lexer (
    input  logic                  clk,
    input  logic                  rst_n,
    cst_in_if.sink                char_in,
    input  logic                  room,
    output cst_pkg::push_t        push
);
    import cst_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_ch_reg;
    logic       stage_end_reg;

    mode_t       mode_reg, mode_next;
    coord_t      line_reg, line_next;
    coord_t      col_reg, col_next;
    coord_t      rsl_reg, rsl_next;
    coord_t      rsc_reg, rsc_next;
    coord_t      rlen_reg, rlen_next;
    logic [31:0] kw_reg, kw_next;

    logic      fire;
    logic      in_beat;
    logic [7:0] c;
    logic      c_digit, c_idch, c_space, cont;
    op_match_t op;
    logic      a_valid, b_valid;
    token_t    tok_a, tok_b;

    assign fire          = stage_valid_reg && room;
    assign char_in.ready = !stage_valid_reg || fire;
    assign in_beat       = char_in.valid && char_in.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_beat)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            stage_ch_reg  <= char_in.ch;
            stage_end_reg <= char_in.is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= COORD_ONE;
            col_reg  <= COORD_ONE;
            rsl_reg  <= COORD_ONE;
            rsc_reg  <= COORD_ONE;
            rlen_reg <= '0;
            kw_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            rsl_reg  <= rsl_next;
            rsc_reg  <= rsc_next;
            rlen_reg <= rlen_next;
            kw_reg   <= kw_next;
        end
    end

    always_comb
    begin
        c       = stage_ch_reg;
        c_digit = is_digit(c);
        c_idch  = c_digit || is_alpha(c) || (c == CH_UNDER);
        c_space = is_space(c);
        op      = op_lookup(c);
        cont    = ((mode_reg == MODE_NUM) && c_digit) || ((mode_reg == MODE_ID) && c_idch);

        mode_next = mode_reg;
        line_next = line_reg;
        col_next  = col_reg;
        rsl_next  = rsl_reg;
        rsc_next  = rsc_reg;
        rlen_next = rlen_reg;
        kw_next   = kw_reg;

        a_valid          = 1'b0;
        tok_a.kind       = (mode_reg == MODE_NUM) ? KIND_NUM : KIND_ID;
        if ((mode_reg == MODE_ID) && (rlen_reg == coord_t'(2)) && (kw_reg == KW_IF))
        begin
            tok_a.kind = KIND_IF;
        end
        if ((mode_reg == MODE_ID) && (rlen_reg == coord_t'(4)) && (kw_reg == KW_ELSE))
        begin
            tok_a.kind = KIND_ELSE;
        end
        tok_a.start_line = 16'(rsl_reg);
        tok_a.start_col  = 16'(rsc_reg);
        tok_a.length     = 16'(rlen_reg);
        tok_a.bad_char   = '0;
        tok_a.last       = 1'b0;

        b_valid          = 1'b0;
        tok_b.kind       = op.kind;
        tok_b.start_line = 16'(line_reg);
        tok_b.start_col  = 16'(col_reg);
        tok_b.length     = 16'd1;
        tok_b.bad_char   = '0;
        tok_b.last       = 1'b1;

        if (stage_end_reg)
        begin
            a_valid      = (mode_reg == MODE_NUM) || (mode_reg == MODE_ID);
            b_valid      = 1'b1;
            tok_b.kind   = KIND_EOF;
            tok_b.length = '0;
            mode_next    = MODE_IDLE;
            line_next    = COORD_ONE;
            col_next     = COORD_ONE;
            rsl_next     = COORD_ONE;
            rsc_next     = COORD_ONE;
            rlen_next    = '0;
            kw_next      = '0;
        end
        else if (mode_reg == MODE_HALT)
        begin
            mode_next = MODE_HALT;
        end
        else
        begin
            // advance position for every consumed byte while not halted
            if (c == CH_NEWLINE)
            begin
                line_next = sat_inc(line_reg);
                col_next  = COORD_ONE;
            end
            else
            begin
                col_next = sat_inc(col_reg);
            end

            if (cont)
            begin
                rlen_next = sat_inc(rlen_reg);
                kw_next   = {kw_reg[23:0], c};
            end
            else
            begin
                a_valid   = (mode_reg == MODE_NUM) || (mode_reg == MODE_ID);
                mode_next = MODE_IDLE;
                if (c_digit || c_idch)
                begin
                    mode_next = c_digit ? MODE_NUM : MODE_ID;
                    rsl_next  = line_reg;
                    rsc_next  = col_reg;
                    rlen_next = COORD_ONE;
                    kw_next   = {24'd0, c};
                end
                else if (!c_space)
                begin
                    b_valid = 1'b1;
                    if (!op.hit)
                    begin
                        tok_b.kind     = KIND_ERR;
                        tok_b.bad_char = c;
                        mode_next      = MODE_HALT;
                    end
                end
            end
        end

        tok_a.last = !b_valid;

        push.tok0  = a_valid ? tok_a : tok_b;
        push.tok1  = tok_b;
        push.count = fire ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    end

endmodule

// ===== rtl/core/cst_outq.sv =====
module cst_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cst_pkg::push_t         push,
    output cst_pkg::queue_status_t status,
    cst_out_if.source              tok_out
);
    import cst_pkg::*;

    token_t     entry_reg [3];
    token_t     entry_next [3];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;

    assign pop = tok_out.valid && tok_out.ready;

    assign tok_out.valid      = (count_reg != 2'd0);
    assign tok_out.kind       = entry_reg[0].kind;
    assign tok_out.start_line = entry_reg[0].start_line;
    assign tok_out.start_col  = entry_reg[0].start_col;
    assign tok_out.length     = entry_reg[0].length;
    assign tok_out.bad_char   = entry_reg[0].bad_char;
    assign tok_out.last       = entry_reg[0].last;

    always_comb
    begin
        base         = count_reg - 2'(pop);
        status.count = count_reg;
        status.room  = (base <= (QUEUE_DEPTH - 2'd2));
        count_next   = base + push.count;

        // drop the head on a beat, then append at the tail
        entry_next[0] = pop ? entry_reg[1] : entry_reg[0];
        entry_next[1] = pop ? entry_reg[2] : entry_reg[1];
        entry_next[2] = entry_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            if ((push.count != 2'd0) && (2'(i) == base))
            begin
                entry_next[i] = push.tok0;
            end
            if ((push.count == 2'd2) && (2'(i) == base + 2'd1))
            begin
                entry_next[i] = push.tok1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/char_stream_tokenizer_top.sv =====
// channel   dir  modport  payload
// char_in   in   sink     ch[7:0], is_end
// tok_out   out  source   kind[4:0], start_line, start_col, length, bad_char[7:0], last
//
// One input beat per cycle while the queue has room; each beat passes through the input stage register.
// A beat yields up to two tokens into a three-entry output queue; one token leaves per cycle while ready.
// The input stage holds while the queue lacks room for two tokens.
// Reset returns line and column to 1, closes any run, and empties the queue.
module char_stream_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    cst_in_if.sink    char_in,
    cst_out_if.source tok_out
);
    import cst_pkg::*;

    push_t         push;
    queue_status_t status;

    cst_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .room    (status.room),
        .push    (push)
    );

    cst_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .status  (status),
        .tok_out (tok_out)
    );

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> status.room)
        else $error("tokens pushed without queue room");

    a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("more than two tokens from one beat");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= QUEUE_DEPTH)
        else $error("output queue overflow");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_out.valid && (tok_out.kind == KIND_EOF)) |-> tok_out.last)
        else $error("end-of-file token not marked last");
`endif

endmodule

// ===== dv/char_stream_tokenizer_top_test.sv =====
`timescale 1ns / 1ps

module char_stream_tokenizer_top_test;

    import cst_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BEATS = 1850;

    localparam int RX_OPEN   = 0;
    localparam int RX_LIGHT  = 1;
    localparam int RX_HEAVY  = 2;
    localparam int RX_TOGGLE = 3;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    class token_scoreboard;
        token_t      pending_tokens[$];
        int          errors;
        int          seen;
        mode_t       mode;
        coord_t      line_no;
        coord_t      col_no;
        coord_t      run_line;
        coord_t      run_col;
        coord_t      run_len;
        logic [31:0] tail;
        string       op_chars;

        function new();
            op_chars = "+-*/=();><{}";
            errors = 0;
            seen = 0;
            restart();
        endfunction

        function void restart();
            mode = MODE_IDLE;
            line_no = COORD_ONE;
            col_no = COORD_ONE;
            run_line = COORD_ONE;
            run_col = COORD_ONE;
            run_len = '0;
            tail = '0;
        endfunction

        function coord_t bump(coord_t v);
            return (v == COORD_MAX) ? v : coord_t'(v + 1'b1);
        endfunction

        function bit is_digit_ch(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_word_start(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function int op_index(logic [7:0] c);
            for (int i = 0; i < op_chars.len(); i++)
                if (op_chars[i] == c)
                    return i;
            return -1;
        endfunction

        function bit known(logic [7:0] c);
            return is_digit_ch(c) || is_word_start(c) || is_blank(c) || op_index(c) >= 0;
        endfunction

        function void push(logic [4:0] kind, coord_t ln, coord_t col, coord_t len,
                           logic [7:0] bad);
            pending_tokens.insert(pending_tokens.size(),
                                  token_t'({kind, ln, col, len, bad, 1'b0}));
        endfunction

        function void advance(logic [7:0] c);
            if (c == CH_NEWLINE)
            begin
                line_no = bump(line_no);
                col_no = COORD_ONE;
            end
            else
                col_no = bump(col_no);
        endfunction

        function void open_run(mode_t m, logic [7:0] c);
            mode = m;
            run_line = line_no;
            run_col = col_no;
            run_len = COORD_ONE;
            tail = {24'h0, c};
        endfunction

        function int close_run();
            logic [4:0] kind;
            if (mode == MODE_NUM)
                kind = KIND_NUM;
            else if (mode == MODE_ID)
            begin
                kind = KIND_ID;
                if (run_len == coord_t'(2) && tail == KW_IF)
                    kind = KIND_IF;
                if (run_len == coord_t'(4) && tail == KW_ELSE)
                    kind = KIND_ELSE;
            end
            else
                return 0;
            push(kind, run_line, run_col, run_len, '0);
            mode = MODE_IDLE;
            return 1;
        endfunction

        // returns 0 when the beat is dropped by a halted lexer
        function bit take_char(logic [7:0] c, logic e);
            int n;
            int op;
            n = 0;
            if (e)
            begin
                n += close_run();
                push(KIND_EOF, line_no, col_no, '0, '0);
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
                restart();
                return 1'b1;
            end
            if (mode == MODE_HALT)
                return 1'b0;
            if (mode == MODE_NUM)
            begin
                if (is_digit_ch(c))
                begin
                    run_len = bump(run_len);
                    advance(c);
                    return 1'b1;
                end
                n += close_run();
            end
            else if (mode == MODE_ID)
            begin
                if (is_digit_ch(c) || is_word_start(c))
                begin
                    run_len = bump(run_len);
                    tail = {tail[23:0], c};
                    advance(c);
                    return 1'b1;
                end
                n += close_run();
            end
            if (is_digit_ch(c))
                open_run(MODE_NUM, c);
            else if (is_word_start(c))
                open_run(MODE_ID, c);
            else if (!is_blank(c))
            begin
                op = op_index(c);
                if (op >= 0)
                    push(5'(KIND_PLUS + op), line_no, col_no, COORD_ONE, '0);
                else
                begin
                    push(KIND_ERR, line_no, col_no, COORD_ONE, c);
                    mode = MODE_HALT;
                end
                n++;
            end
            advance(c);
            if (n > 0)
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("token %0d %s: got %0d expected %0d", seen, what, got, want);
        endtask

        task match_token(token_t got);
            token_t want;
            seen++;
            if (pending_tokens.size() == 0)
            begin
                report("unexpected, kind", 32'(got.kind), 32'd0);
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)
                report("kind", 32'(got.kind), 32'(want.kind));
            if (got.start_line !== want.start_line)
                report("start_line", 32'(got.start_line), 32'(want.start_line));
            if (got.start_col !== want.start_col)
                report("start_col", 32'(got.start_col), 32'(want.start_col));
            if (got.length !== want.length)
                report("length", 32'(got.length), 32'(want.length));
            if (got.bad_char !== want.bad_char)
                report("bad_char", 32'(got.bad_char), 32'(want.bad_char));
            if (got.last !== want.last)
                report("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cst_in_if  char_bus ();
    cst_out_if token_bus ();

    char_stream_tokenizer_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .tok_out (token_bus)
    );

    token_scoreboard sb = new();

    int cycle_count;
    int live_beats;
    int burst_left;
    int hold_ticket;
    bit gaps_on;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && token_bus.valid && token_bus.ready)
            sb.match_token({token_bus.kind, token_bus.start_line, token_bus.start_col,
                            token_bus.length, token_bus.bad_char, token_bus.last});
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int seg;
        int style;
        int hold;
        int ticket_seen;
        seg = 0;
        style = RX_OPEN;
        hold = 0;
        ticket_seen = 0;
        token_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != ticket_seen)
            begin
                ticket_seen = hold_ticket;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                token_bus.ready <= 1'b0;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg = $urandom_range(10, 200);
                    style = $urandom_range(RX_OPEN, RX_TOGGLE);
                end
                seg--;
                case (style)
                    RX_OPEN:  token_bus.ready <= 1'b1;
                    RX_LIGHT: token_bus.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: token_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:  token_bus.ready <= ~token_bus.ready;
                endcase
            end
        end
    end

    // enter and leave on a rising edge
    task automatic send_beat(logic [7:0] c, logic e);
        int gap;
        char_bus.valid <= 1'b1;
        char_bus.ch <= c;
        char_bus.is_end <= e;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        live_beats += sb.take_char(c, e);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 6);
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        char_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'(8'h61 + r);
        if (r < 52)
            return 8'(8'h41 + r - 26);
        if (r < 62)
            return 8'(8'h30 + r - 52);
        return CH_UNDER;
    endfunction

    task automatic send_source();
        string      near_words [9] = '{"i", "el", "els", "iff", "elses", "If", "ELSE",
                                       "_if", "if_"};
        int         pieces;
        int         pick;
        int         len;
        logic [7:0] c;
        if ($urandom_range(0, 19) == 0)
        begin
            len = $urandom_range(1, 12);
            repeat (len) send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            pieces = $urandom_range(1, 16);
            for (int i = 0; i < pieces; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    len = $urandom_range(0, 7);
                    c = ($urandom_range(0, 9) == 0) ? CH_UNDER :
                        ($urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
                                              : 8'(8'h41 + $urandom_range(0, 25)));
                    send_beat(c, 1'b0);
                    repeat (len) send_beat(word_char(), 1'b0);
                end
                else if (pick < 35)
                    send_text($urandom_range(0, 1) ? "if" : "else");
                else if (pick < 45)
                    send_text(near_words[$urandom_range(0, 8)]);
                else if (pick < 65)
                begin
                    len = $urandom_range(1, 6);
                    repeat (len) send_beat(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
                end
                else if (pick < 85)
                    send_beat(sb.op_chars[$urandom_range(0, 11)], 1'b0);
                else if (pick < 97)
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_beat(BLANKS[$urandom_range(0, 5)], 1'b0);
                end
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (sb.known(c));
                    send_beat(c, 1'b0);
                    len = $urandom_range(0, 4);
                    repeat (len) send_beat(8'($urandom_range(0, 255)), 1'b0);
                    break;
                end
                if ($urandom_range(0, 1))
                    send_beat(BLANKS[$urandom_range(0, 5)], 1'b0);
            end
        end
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        int sources;
        rst_n <= 1'b0;
        char_bus.valid <= 1'b0;
        char_bus.ch <= '0;
        char_bus.is_end <= 1'b0;
        gaps_on = 1'b1;
        burst_left = 0;
        hold_ticket = 0;
        live_beats = 0;
        sources = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("if\nelse 12ab+-*/=();><{}");
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        wait_drained();

        live_beats = 0;
        while (live_beats < RANDOM_BEATS)
        begin
            sources++;
            if (sources % 8 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (sources == 12)
            begin
                hold_ticket++;
                gaps_on = 1'b0;
            end
            if (sources == 30)
                wait_drained();
            send_source();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
